// ===== hw/rtl/smseq_pkg.sv =====
// Shared types and constants for the shooter mode sequencer.
// Depends on nothing; used by shooter_mode_sequencer_core.
package smseq_pkg;

   // Shooter modes as seen on the result channel
   typedef enum logic [1:0] {
      MODE_STOP  = 2'd0,
      MODE_PREP  = 2'd1,
      MODE_SHOOT = 2'd2,
      MODE_TRANS = 2'd3
   } mode_type;

   // Item kinds
   typedef enum logic {
      FUNC_TICK    = 1'b0,
      FUNC_REQUEST = 1'b1
   } func_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_TARGET_RPM    = 2'd0,
      CSR_HOOD_SETPOINT = 2'd1,
      CSR_PREP_FRACTION = 2'd2,
      CSR_STOP_DELAY    = 2'd3
   } csr_index_type;

   localparam int CSR_DATA_W = 17;

   // Field widths
   localparam int RPM_W   = 14;
   localparam int FRAC_W  = 11;
   localparam int HOOD_W  = 17;
   localparam int VEL_W   = 19;
   localparam int SPD_W   = 25;   // velocity * 60
   localparam int PREPQ_W = 24;   // rpm in 1/1024 units
   localparam int DIFF_W  = 26;
   localparam int DELAY_W = 16;
   localparam int DUTY_W  = 10;

   // Limits and tolerances
   localparam logic [RPM_W-1:0]         RPM_MAX   = 14'd12000;
   localparam logic [FRAC_W-1:0]        FRAC_MAX  = 11'd1024;
   localparam logic signed [DIFF_W-1:0] SETTLE_Q  = 26'sd61440;
   localparam logic signed [SPD_W-1:0]  STOPPED_Q = 25'sd512;
   localparam logic signed [HOOD_W:0]   HOOD_TOL  = 18'sd128;

   // Kicker duties in per-mille
   localparam logic [DUTY_W-1:0] DUTY_RUN      = 10'd750;
   localparam logic [DUTY_W-1:0] DUTY_STOPPING = 10'd500;
   localparam logic [DUTY_W-1:0] DUTY_PREP     = 10'd150;
   localparam logic [DUTY_W-1:0] DUTY_OFF      = 10'd0;

   // Reset values of the configuration registers
   localparam logic [RPM_W-1:0]         TARGET_RPM_RST = 14'd3000;
   localparam logic signed [HOOD_W-1:0] HOOD_SET_RST   = 17'sd0;
   localparam logic [FRAC_W-1:0]        PREP_FRAC_RST  = 11'd307;
   localparam logic [DELAY_W-1:0]       STOP_DELAY_RST = 16'd25;

endpackage

// ===== hw/rtl/shooter_mode_sequencer_core.sv =====
// Shooter mode sequencer: mode requests, periodic ticks, kicker run-on timer.
// Depends on smseq_pkg (types, modes, duties, tolerances).
//
// Usage
//   req_*  : one beat per item. req_func selects a periodic tick (velocity and
//            hood position sampled) or a mode request (req_desired_mode).
//   rsp_*  : exactly one beat per item, in order: flywheel, kicker and hood
//            commands with their valid flags, plus the mode after the item.
//            A mode request returns all flags and commands at zero.
//   csr_*  : plain write port, one register per cycle with csr_wr_en high;
//            write only while no item is in flight.
// Timing
//   An item is taken into the input register, worked on there and lands in
//   the result register, where the result beat is offered. While rsp_stall
//   stays low, one item per cycle is sustained; the single pass from input
//   register to result register, where the mode state also updates, sets it.
// Reset
//   Synchronous, active high: mode stop, requested stop, run-on timer idle,
//   configuration back to its defaults, both pipeline stages empty.
// Stall
//   While rsp_stall holds a result, the input register still takes one more
//   beat; with both stages full, req_stall rises until the result is taken.
module shooter_mode_sequencer_core #(
   parameter int TIMER_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // input channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_func,
   input  logic [1:0]                           req_desired_mode,
   input  logic signed [smseq_pkg::VEL_W-1:0]   req_flywheel_velocity,
   input  logic signed [smseq_pkg::HOOD_W-1:0]  req_hood_position,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_flywheel_cmd_valid,
   output logic [smseq_pkg::RPM_W-1:0]          rsp_flywheel_rpm_cmd,
   output logic                                 rsp_kicker_cmd_valid,
   output logic [smseq_pkg::DUTY_W-1:0]         rsp_kicker_duty,
   output logic                                 rsp_hood_cmd_valid,
   output logic signed [smseq_pkg::HOOD_W-1:0]  rsp_hood_cmd,
   output logic [1:0]                           rsp_mode,
   // configuration
   input  logic                                 csr_wr_en,
   input  logic [1:0]                           csr_index,
   input  logic [smseq_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int CNT_W = (TIMER_BITS > smseq_pkg::DELAY_W) ? TIMER_BITS : smseq_pkg::DELAY_W;

   // ---------------------------------------------------------------- config
   logic [smseq_pkg::RPM_W-1:0]         target_rpm_ff;
   logic signed [smseq_pkg::HOOD_W-1:0] hood_setpoint_ff;
   logic [smseq_pkg::FRAC_W-1:0]        prep_fraction_ff;
   logic [smseq_pkg::DELAY_W-1:0]       stop_delay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_rpm_ff    <= smseq_pkg::TARGET_RPM_RST;
         hood_setpoint_ff <= smseq_pkg::HOOD_SET_RST;
         prep_fraction_ff <= smseq_pkg::PREP_FRAC_RST;
         stop_delay_ff    <= smseq_pkg::STOP_DELAY_RST;
      end else if (csr_wr_en) begin
         unique case (smseq_pkg::csr_index_type'(csr_index))
            smseq_pkg::CSR_TARGET_RPM:    target_rpm_ff    <= csr_wdata[13:0];
            smseq_pkg::CSR_HOOD_SETPOINT: hood_setpoint_ff <= $signed(csr_wdata[16:0]);
            smseq_pkg::CSR_PREP_FRACTION: prep_fraction_ff <= csr_wdata[10:0];
            smseq_pkg::CSR_STOP_DELAY:    stop_delay_ff    <= csr_wdata[15:0];
         endcase
      end
   end

   // Clamp target and fraction, precompute prep speed once per cycle from regs;
   // the user keeps configuration quiet while items are in flight (unenforced).
   logic [smseq_pkg::RPM_W-1:0]   tgt;
   logic [smseq_pkg::FRAC_W-1:0]  frac;
   logic [smseq_pkg::PREPQ_W-1:0] prep_q_in, prep_q_ff;
   logic [smseq_pkg::PREPQ_W-1:0] prep_round;
   logic [smseq_pkg::RPM_W-1:0]   prep_rpm_in, prep_rpm_ff;

   assign tgt  = (target_rpm_ff > smseq_pkg::RPM_MAX) ? smseq_pkg::RPM_MAX : target_rpm_ff;
   assign frac = (prep_fraction_ff > smseq_pkg::FRAC_MAX) ? smseq_pkg::FRAC_MAX
                                                          : prep_fraction_ff;
   assign prep_q_in   = smseq_pkg::PREPQ_W'(tgt) * smseq_pkg::PREPQ_W'(frac);
   assign prep_round  = prep_q_in + smseq_pkg::PREPQ_W'(512);
   assign prep_rpm_in = prep_round[23:10];

   always_ff @(posedge clock) begin
      prep_q_ff   <= prep_q_in;
      prep_rpm_ff <= prep_rpm_in;
   end

   // ------------------------------------------------------- input register
   logic                                in_valid_ff;
   logic                                in_func_ff;
   logic [1:0]                          in_mode_ff;
   logic signed [smseq_pkg::SPD_W-1:0]  in_spd_ff;
   logic signed [smseq_pkg::HOOD_W-1:0] in_hood_ff;
   logic signed [smseq_pkg::SPD_W-1:0]  vel_x, spd_in;
   logic                                advance;
   logic                                req_take;

   // Speed in 1/1024 RPM: velocity * 60 = velocity * 64 - velocity * 4
   assign vel_x  = smseq_pkg::SPD_W'(req_flywheel_velocity);
   assign spd_in = (vel_x <<< 6) - (vel_x <<< 2);

   assign advance   = in_valid_ff && (!rsp_valid || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= req_take || (in_valid_ff && !advance);
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_func_ff <= req_func;
         in_mode_ff <= req_desired_mode;
         in_spd_ff  <= spd_in;
         in_hood_ff <= req_hood_position;
      end
   end

   // ------------------------------------------------------------ state
   smseq_pkg::mode_type  cur_mode_ff, cur_mode_in;
   smseq_pkg::mode_type  req_mode_ff, req_mode_in;
   logic                 runon_active_ff, runon_active_in;
   logic [TIMER_BITS-1:0] runon_count_ff, runon_count_in;

   // Settling checks on the held tick
   logic signed [smseq_pkg::DIFF_W-1:0] prep_err, tgt_err;
   logic signed [smseq_pkg::HOOD_W:0]   hood_err;
   logic                                prep_settled, tgt_settled, hood_settled, stopped;
   logic                                delay_reached;

   assign prep_err = $signed({2'b00, prep_q_ff}) - smseq_pkg::DIFF_W'(in_spd_ff);
   assign tgt_err  = $signed({2'b00, tgt, 10'b0}) - smseq_pkg::DIFF_W'(in_spd_ff);
   assign hood_err = (smseq_pkg::HOOD_W+1)'(hood_setpoint_ff)
                   - (smseq_pkg::HOOD_W+1)'(in_hood_ff);

   assign prep_settled = (prep_err > -smseq_pkg::SETTLE_Q) && (prep_err < smseq_pkg::SETTLE_Q);
   assign tgt_settled  = (tgt_err > -smseq_pkg::SETTLE_Q) && (tgt_err < smseq_pkg::SETTLE_Q);
   assign hood_settled = (hood_err > -smseq_pkg::HOOD_TOL) && (hood_err < smseq_pkg::HOOD_TOL);
   assign stopped      = (in_spd_ff > -smseq_pkg::STOPPED_Q) && (in_spd_ff < smseq_pkg::STOPPED_Q);

   // Result fields of the item in flight
   logic                                fv, kv, hv;
   logic [smseq_pkg::RPM_W-1:0]         frpm;
   logic [smseq_pkg::DUTY_W-1:0]        kd;
   logic signed [smseq_pkg::HOOD_W-1:0] hc;

   always_comb begin
      cur_mode_in     = cur_mode_ff;
      req_mode_in     = req_mode_ff;
      runon_active_in = runon_active_ff;
      runon_count_in  = runon_count_ff;
      fv   = 1'b0;
      frpm = '0;
      kv   = 1'b0;
      kd   = smseq_pkg::DUTY_OFF;
      hv   = 1'b0;
      hc   = '0;
      delay_reached = 1'b0;

      if (smseq_pkg::func_type'(in_func_ff) == smseq_pkg::FUNC_REQUEST) begin
         // Drop a request for the transition code itself
         if (smseq_pkg::mode_type'(in_mode_ff) != smseq_pkg::MODE_TRANS) begin
            req_mode_in = smseq_pkg::mode_type'(in_mode_ff);
            if (smseq_pkg::mode_type'(in_mode_ff) != cur_mode_ff) begin
               cur_mode_in = smseq_pkg::MODE_TRANS;
            end
         end
      end else begin
         unique case (cur_mode_ff)
            smseq_pkg::MODE_STOP: begin
               if (runon_active_ff) begin
                  kv = 1'b1;
                  if (CNT_W'(runon_count_ff) >= CNT_W'(stop_delay_ff)) begin
                     kd              = smseq_pkg::DUTY_OFF;
                     runon_active_in = 1'b0;
                     runon_count_in  = '0;
                  end else begin
                     kd = smseq_pkg::DUTY_RUN;
                  end
               end
            end
            smseq_pkg::MODE_PREP: begin
               runon_active_in = 1'b0;
               runon_count_in  = '0;
               fv   = 1'b1;
               frpm = prep_rpm_ff;
               kv   = 1'b1;
               kd   = smseq_pkg::DUTY_PREP;
            end
            smseq_pkg::MODE_SHOOT: begin
               fv   = 1'b1;
               frpm = tgt;
               kv   = 1'b1;
               kd   = smseq_pkg::DUTY_RUN;
               hv   = 1'b1;
               hc   = hood_setpoint_ff;
            end
            smseq_pkg::MODE_TRANS: begin
               unique case (req_mode_ff)
                  smseq_pkg::MODE_STOP: begin
                     fv = 1'b1;
                     if (!runon_active_ff) begin
                        runon_active_in = 1'b1;
                        runon_count_in  = '0;
                     end
                     delay_reached = CNT_W'(runon_count_in) >= CNT_W'(stop_delay_ff);
                     kv = 1'b1;
                     kd = delay_reached ? smseq_pkg::DUTY_OFF : smseq_pkg::DUTY_STOPPING;
                     hv = 1'b1;
                     if (stopped) begin
                        cur_mode_in = smseq_pkg::MODE_STOP;
                     end
                  end
                  smseq_pkg::MODE_PREP: begin
                     fv   = 1'b1;
                     frpm = prep_rpm_ff;
                     kv   = 1'b1;
                     kd   = smseq_pkg::DUTY_PREP;
                     hv   = 1'b1;
                     if (prep_settled) begin
                        cur_mode_in = smseq_pkg::MODE_PREP;
                     end
                  end
                  smseq_pkg::MODE_SHOOT: begin
                     fv   = 1'b1;
                     frpm = tgt;
                     hv   = 1'b1;
                     hc   = hood_setpoint_ff;
                     if (tgt_settled && hood_settled) begin
                        cur_mode_in = smseq_pkg::MODE_SHOOT;
                     end
                  end
                  smseq_pkg::MODE_TRANS: begin
                     // never requested; hold everything
                  end
               endcase
            end
         endcase

         // Advance the run-on timer, saturating at all ones
         if (runon_active_in && !(&runon_count_in)) begin
            runon_count_in = runon_count_in + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_mode_ff     <= smseq_pkg::MODE_STOP;
         req_mode_ff     <= smseq_pkg::MODE_STOP;
         runon_active_ff <= 1'b0;
         runon_count_ff  <= '0;
      end else if (advance) begin
         cur_mode_ff     <= cur_mode_in;
         req_mode_ff     <= req_mode_in;
         runon_active_ff <= runon_active_in;
         runon_count_ff  <= runon_count_in;
      end
   end

   // ------------------------------------------------------ result register
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_flywheel_cmd_valid <= fv;
         rsp_flywheel_rpm_cmd   <= frpm;
         rsp_kicker_cmd_valid   <= kv;
         rsp_kicker_duty        <= kd;
         rsp_hood_cmd_valid     <= hv;
         rsp_hood_cmd           <= hc;
         rsp_mode               <= cur_mode_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // ------------------------------------------------------------ checks
   a_request_no_cmds: assert property (@(posedge clock) disable iff (reset)
      advance && (smseq_pkg::func_type'(in_func_ff) == smseq_pkg::FUNC_REQUEST)
      |=> !rsp_flywheel_cmd_valid && !rsp_kicker_cmd_valid && !rsp_hood_cmd_valid)
      else $error("mode request produced a command");

   a_idle_timer_zero: assert property (@(posedge clock) disable iff (reset)
      !runon_active_ff |-> (runon_count_ff == '0))
      else $error("run-on count nonzero while idle");

   a_settled_mode_matches: assert property (@(posedge clock) disable iff (reset)
      (cur_mode_ff != smseq_pkg::MODE_TRANS) |-> (cur_mode_ff == req_mode_ff))
      else $error("settled mode differs from requested mode");

   a_full_pipe_stalls: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while both stages are full");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for shooter_mode_sequencer_core: sends ticks and mode
// requests, predicts each result beat in-line and compares it field by field.
// Depends on smseq_pkg and the shooter_mode_sequencer_core RTL.
module tb;

   localparam int TIMER_BITS  = 16;
   localparam int CYCLE_LIMIT = 500000;
   // A result passes the input register, then the result register; pad the wait.
   localparam int LATENCY     = 2;

   // One input beat as the sender sees it
   typedef struct {
      smseq_pkg::func_type                 func;
      logic [1:0]                          want;
      logic signed [smseq_pkg::VEL_W-1:0]  vel;
      logic signed [smseq_pkg::HOOD_W-1:0] hood;
   } shooter_item_type;

   // One result beat: the commands that a tick or request produces
   typedef struct {
      logic                                fly_valid;
      logic [smseq_pkg::RPM_W-1:0]         fly_rpm;
      logic                                kick_valid;
      logic [smseq_pkg::DUTY_W-1:0]        kick_duty;
      logic                                hood_valid;
      logic signed [smseq_pkg::HOOD_W-1:0] hood_cmd;
      smseq_pkg::mode_type                 mode;
   } shooter_cmd_type;

   // Every input driven to a known value from time zero
   logic                                clock            = 1'b0;
   logic                                reset            = 1'b1;
   logic                                req_valid        = 1'b0;
   logic                                req_stall;
   logic                                req_func         = smseq_pkg::FUNC_TICK;
   logic [1:0]                          req_desired_mode = '0;
   logic signed [smseq_pkg::VEL_W-1:0]  req_flywheel_velocity = '0;
   logic signed [smseq_pkg::HOOD_W-1:0] req_hood_position     = '0;
   logic                                rsp_valid;
   logic                                rsp_stall        = 1'b0;
   logic                                rsp_flywheel_cmd_valid;
   logic [smseq_pkg::RPM_W-1:0]         rsp_flywheel_rpm_cmd;
   logic                                rsp_kicker_cmd_valid;
   logic [smseq_pkg::DUTY_W-1:0]        rsp_kicker_duty;
   logic                                rsp_hood_cmd_valid;
   logic signed [smseq_pkg::HOOD_W-1:0] rsp_hood_cmd;
   logic [1:0]                          rsp_mode;
   logic                                csr_wr_en        = 1'b0;
   logic [1:0]                          csr_index        = smseq_pkg::CSR_TARGET_RPM;
   logic [smseq_pkg::CSR_DATA_W-1:0]    csr_wdata        = '0;

   shooter_mode_sequencer_core #(.TIMER_BITS(TIMER_BITS)) i_dut (.*);

   always #5 clock = ~clock;

   // Predictor copy of the configuration, starting at the reset defaults
   logic [smseq_pkg::RPM_W-1:0]         cfg_target = smseq_pkg::TARGET_RPM_RST;
   logic signed [smseq_pkg::HOOD_W-1:0] cfg_hood   = smseq_pkg::HOOD_SET_RST;
   logic [smseq_pkg::FRAC_W-1:0]        cfg_frac   = smseq_pkg::PREP_FRAC_RST;
   logic [smseq_pkg::DELAY_W-1:0]       cfg_delay  = smseq_pkg::STOP_DELAY_RST;

   // Predictor copy of the sequencer state
   smseq_pkg::mode_type      mdl_mode   = smseq_pkg::MODE_STOP;
   smseq_pkg::mode_type      mdl_goal   = smseq_pkg::MODE_STOP;
   logic                     runon_on   = 1'b0;
   logic [TIMER_BITS-1:0]    runon_cnt  = '0;

   // Commands predicted for accepted beats, oldest first
   shooter_cmd_type          pending_cmds[$];

   int idle_pct    = 28;
   int stall_pct   = 28;
   int mismatches  = 0;
   int n_items     = 0;
   int n_ticks     = 0;
   int n_results   = 0;
   int n_settings  = 0;
   int cycle_count = 0;

   function automatic longint mag(longint x);
      return (x < 0) ? -x : x;
   endfunction

   // Flywheel goal in 1/1024 RPM for a mode, with the register clamps applied
   function automatic longint goal_speed_q(smseq_pkg::mode_type m);
      longint tgt;
      longint frac;
      tgt  = (cfg_target > smseq_pkg::RPM_MAX) ? smseq_pkg::RPM_MAX : cfg_target;
      frac = (cfg_frac > smseq_pkg::FRAC_MAX) ? smseq_pkg::FRAC_MAX : cfg_frac;
      case (m)
         smseq_pkg::MODE_PREP:  return tgt * frac;
         smseq_pkg::MODE_SHOOT: return tgt * 1024;
         default:               return 0;
      endcase
   endfunction

   // Work out the result of one accepted beat and advance the state
   function automatic shooter_cmd_type advance_sequencer(shooter_item_type it);
      shooter_cmd_type c;
      longint       spd_q;
      longint       hood_err;
      logic [smseq_pkg::RPM_W-1:0] prep_rpm;
      logic [smseq_pkg::RPM_W-1:0] full_rpm;
      c.fly_valid  = 1'b0;
      c.fly_rpm    = '0;
      c.kick_valid = 1'b0;
      c.kick_duty  = smseq_pkg::DUTY_OFF;
      c.hood_valid = 1'b0;
      c.hood_cmd   = '0;
      prep_rpm = smseq_pkg::RPM_W'((goal_speed_q(smseq_pkg::MODE_PREP) + 512) >>> 10);
      full_rpm = smseq_pkg::RPM_W'(goal_speed_q(smseq_pkg::MODE_SHOOT) >>> 10);
      spd_q    = longint'(it.vel) * 60;
      hood_err = longint'(cfg_hood) - longint'(it.hood);
      if (it.func == smseq_pkg::FUNC_REQUEST) begin
         // Mode three is dropped; a new mode enters transition
         if (it.want != smseq_pkg::MODE_TRANS) begin
            mdl_goal = smseq_pkg::mode_type'(it.want);
            if (mdl_goal != mdl_mode)
               mdl_mode = smseq_pkg::MODE_TRANS;
         end
      end else begin
         case (mdl_mode)
            smseq_pkg::MODE_STOP: begin
               if (runon_on) begin
                  c.kick_valid = 1'b1;
                  if (runon_cnt >= cfg_delay) begin
                     c.kick_duty = smseq_pkg::DUTY_OFF;
                     runon_on    = 1'b0;
                     runon_cnt   = '0;
                  end else begin
                     c.kick_duty = smseq_pkg::DUTY_RUN;
                  end
               end
            end
            smseq_pkg::MODE_PREP: begin
               runon_on     = 1'b0;
               runon_cnt    = '0;
               c.fly_valid  = 1'b1;
               c.fly_rpm    = prep_rpm;
               c.kick_valid = 1'b1;
               c.kick_duty  = smseq_pkg::DUTY_PREP;
            end
            smseq_pkg::MODE_SHOOT: begin
               c.fly_valid  = 1'b1;
               c.fly_rpm    = full_rpm;
               c.kick_valid = 1'b1;
               c.kick_duty  = smseq_pkg::DUTY_RUN;
               c.hood_valid = 1'b1;
               c.hood_cmd   = cfg_hood;
            end
            default: begin
               case (mdl_goal)
                  smseq_pkg::MODE_STOP: begin
                     c.fly_valid = 1'b1;
                     if (!runon_on) begin
                        runon_on  = 1'b1;
                        runon_cnt = '0;
                     end
                     c.kick_valid = 1'b1;
                     c.kick_duty  = (runon_cnt < cfg_delay) ? smseq_pkg::DUTY_STOPPING
                                                            : smseq_pkg::DUTY_OFF;
                     c.hood_valid = 1'b1;
                     if (mag(spd_q) < smseq_pkg::STOPPED_Q)
                        mdl_mode = smseq_pkg::MODE_STOP;
                  end
                  smseq_pkg::MODE_PREP: begin
                     c.fly_valid  = 1'b1;
                     c.fly_rpm    = prep_rpm;
                     c.kick_valid = 1'b1;
                     c.kick_duty  = smseq_pkg::DUTY_PREP;
                     c.hood_valid = 1'b1;
                     if (mag(goal_speed_q(smseq_pkg::MODE_PREP) - spd_q) < smseq_pkg::SETTLE_Q)
                        mdl_mode = smseq_pkg::MODE_PREP;
                  end
                  smseq_pkg::MODE_SHOOT: begin
                     c.fly_valid  = 1'b1;
                     c.fly_rpm    = full_rpm;
                     c.hood_valid = 1'b1;
                     c.hood_cmd   = cfg_hood;
                     if (mag(goal_speed_q(smseq_pkg::MODE_SHOOT) - spd_q) < smseq_pkg::SETTLE_Q
                         && mag(hood_err) < smseq_pkg::HOOD_TOL)
                        mdl_mode = smseq_pkg::MODE_SHOOT;
                  end
                  default: ;
               endcase
            end
         endcase
         // Count the run-on, holding at full scale
         if (runon_on && runon_cnt != '1)
            runon_cnt = runon_cnt + 1'b1;
      end
      c.mode = mdl_mode;
      return c;
   endfunction

   // Random value around a center, clamped to a signed field of w bits
   function automatic longint jitter_around(longint center, int unsigned spread,
                                            int unsigned w);
      longint v;
      longint hi;
      hi = (longint'(1) <<< (w - 1)) - 1;
      v  = center + longint'($urandom_range(2 * spread)) - longint'(spread);
      if (v > hi)
         v = hi;
      if (v < -hi - 1)
         v = -hi - 1;
      return v;
   endfunction

   // Build a tick aimed at the pending goal: settled ones land inside the
   // tolerances, the rest straddle them or roam the whole range.
   function automatic shooter_item_type make_tick(bit settled);
      shooter_item_type it;
      longint        goal_q;
      goal_q  = goal_speed_q(mdl_goal);
      it.func = smseq_pkg::FUNC_TICK;
      it.want = 2'($urandom_range(3));
      if (settled || $urandom_range(99) < 60) begin
         if (mdl_goal == smseq_pkg::MODE_STOP)
            it.vel = smseq_pkg::VEL_W'(jitter_around(0, settled ? 8 : 24, smseq_pkg::VEL_W));
         else
            it.vel = smseq_pkg::VEL_W'(jitter_around(goal_q / 60, settled ? 1000 : 1200,
                                                     smseq_pkg::VEL_W));
         it.hood = smseq_pkg::HOOD_W'(jitter_around(cfg_hood, settled ? 120 : 180,
                                                    smseq_pkg::HOOD_W));
      end else begin
         it.vel  = smseq_pkg::VEL_W'($urandom);
         it.hood = smseq_pkg::HOOD_W'($urandom);
      end
      return it;
   endfunction

   // Send one beat: idle at random, hold the payload until it is taken,
   // then queue its predicted result.
   task automatic push_item(shooter_item_type it);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_func              <= it.func;
      req_desired_mode      <= it.want;
      req_flywheel_velocity <= it.vel;
      req_hood_position     <= it.hood;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      pending_cmds.push_back(advance_sequencer(it));
      n_items++;
      if (it.func == smseq_pkg::FUNC_TICK)
         n_ticks++;
   endtask

   task automatic push_tick(longint v, longint h);
      shooter_item_type it;
      it.func = smseq_pkg::FUNC_TICK;
      it.want = 2'($urandom);
      it.vel  = smseq_pkg::VEL_W'(v);
      it.hood = smseq_pkg::HOOD_W'(h);
      push_item(it);
   endtask

   // Velocity and hood of a request are don't-care; randomize them anyway
   task automatic push_request(logic [1:0] m);
      shooter_item_type it;
      it.func = smseq_pkg::FUNC_REQUEST;
      it.want = m;
      it.vel  = smseq_pkg::VEL_W'($urandom);
      it.hood = smseq_pkg::HOOD_W'($urandom);
      push_item(it);
   endtask

   // Request a mode, spin a few unsettled ticks, settle, then run in the mode
   task automatic run_mode_cycle(logic [1:0] m);
      push_request(m);
      repeat ($urandom_range(3))
         push_item(make_tick(1'b0));
      push_item(make_tick(1'b1));
      repeat ($urandom_range(1, 6))
         push_item(make_tick($urandom_range(1)));
   endtask

   // Drop valid and wait until every predicted result has come back
   task automatic settle_pipeline();
      req_valid <= 1'b0;
      while (pending_cmds.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 2)
         @(posedge clock);
   endtask

   task automatic csr_beat(smseq_pkg::csr_index_type idx,
                           logic [smseq_pkg::CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Write all four registers back to back; unused upper data bits carry junk
   task automatic load_settings(logic [smseq_pkg::RPM_W-1:0] t,
                                logic signed [smseq_pkg::HOOD_W-1:0] h,
                                logic [smseq_pkg::FRAC_W-1:0] f,
                                logic [smseq_pkg::DELAY_W-1:0] d);
      csr_beat(smseq_pkg::CSR_TARGET_RPM,    {3'($urandom), t});
      csr_beat(smseq_pkg::CSR_HOOD_SETPOINT, h);
      csr_beat(smseq_pkg::CSR_PREP_FRACTION, {6'($urandom), f});
      csr_beat(smseq_pkg::CSR_STOP_DELAY,    {1'($urandom), d});
      csr_wr_en  <= 1'b0;
      cfg_target = t;
      cfg_hood   = h;
      cfg_frac   = f;
      cfg_delay  = d;
      n_settings++;
   endtask

   // Walk every mode by hand at the reset settings: ignored and repeated
   // requests, retarget during transition, tolerance edges, run-on kicker.
   task automatic test_directed();
      push_tick(0, 0);
      push_request(smseq_pkg::MODE_TRANS);
      push_request(smseq_pkg::MODE_STOP);
      push_request(smseq_pkg::MODE_PREP);
      push_tick(262143, -65536);
      push_tick(15350, 65535);
      push_tick(-262144, 0);
      push_request(smseq_pkg::MODE_SHOOT);
      push_request(smseq_pkg::MODE_PREP);
      push_request(smseq_pkg::MODE_SHOOT);
      push_tick(51200, 65535);
      push_tick(51200 + 1024, 0);
      push_tick(51200 - 1023, 127);
      push_tick(0, 0);
      push_request(smseq_pkg::MODE_STOP);
      push_tick(-262144, 0);
      push_tick(9, 0);
      push_tick(-8, 0);
      repeat (3)
         push_tick($signed(smseq_pkg::VEL_W'($urandom)), $signed(smseq_pkg::HOOD_W'($urandom)));
      push_request(smseq_pkg::MODE_PREP);
      push_tick(15350, 0);
   endtask

   // Corner register settings: zero target, clamped target and fraction,
   // zero and one-tick run-on, full-scale delay, hood at both ends.
   task automatic test_setting_extremes();
      for (int s = 0; s < 4; s++) begin
         settle_pipeline();
         case (s)
            0: load_settings(14'd0,     -17'sd65536, 11'd0,    16'd0);
            1: load_settings(14'd12000,  17'sd65535, 11'd1024, 16'd1);
            2: load_settings(14'd16383,  17'sd0,     11'd2047, 16'hFFFF);
            default: load_settings(14'd1, -17'sd1,   11'd1,    16'd2);
         endcase
         run_mode_cycle(smseq_pkg::MODE_PREP);
         run_mode_cycle(smseq_pkg::MODE_SHOOT);
         run_mode_cycle(smseq_pkg::MODE_STOP);
         repeat (4)
            push_item(make_tick(1'b1));
         run_mode_cycle(smseq_pkg::MODE_SHOOT);
      end
   endtask

   // Mostly well-formed mode sequences with random content, plus noise beats
   // and broken sequences; pause now and then until the results drain.
   task automatic test_random_traffic();
      shooter_item_type it;
      int            start;
      int unsigned   pick;
      for (int ph = 0; ph < 5; ph++) begin
         settle_pipeline();
         load_settings(($urandom_range(99) < 10) ? 14'($urandom_range(16383))
                                                 : 14'($urandom_range(12000)),
                       smseq_pkg::HOOD_W'($urandom),
                       ($urandom_range(99) < 10) ? 11'($urandom_range(2047))
                                                 : 11'($urandom_range(1024)),
                       ($urandom_range(99) < 15) ? 16'($urandom_range(65535))
                                                 : 16'($urandom_range(12)));
         start = n_items;
         while (n_items - start < 80) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
               run_mode_cycle(2'($urandom_range(2)));
            end else if (pick < 90) begin
               it.func = smseq_pkg::func_type'($urandom_range(1));
               it.want = 2'($urandom);
               it.vel  = smseq_pkg::VEL_W'($urandom);
               it.hood = smseq_pkg::HOOD_W'($urandom);
               push_item(it);
            end else begin
               push_request(2'($urandom));
               push_request(2'($urandom_range(2)));
               push_item(make_tick(1'b0));
            end
            if ($urandom_range(19) == 0)
               settle_pipeline();
         end
      end
   endtask

   // Long run-on with no idling on either side: count the timer through a
   // long delay in stop mode and see the kicker drop once it elapses.
   task automatic test_runon_elapse();
      settle_pipeline();
      load_settings(smseq_pkg::TARGET_RPM_RST, smseq_pkg::HOOD_SET_RST,
                    smseq_pkg::PREP_FRAC_RST, 16'd40);
      idle_pct  = 0;
      stall_pct = 0;
      push_request(smseq_pkg::MODE_PREP);
      push_item(make_tick(1'b1));
      push_request(smseq_pkg::MODE_STOP);
      push_item(make_tick(1'b1));
      repeat (50)
         push_item(make_tick($urandom_range(1)));
      settle_pipeline();
      idle_pct  = 28;
      stall_pct = 28;
   endtask

   // Receiver back-pressure, quiet during reset
   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   function automatic void check_field(string name, logic signed [63:0] want,
                                       logic signed [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // Compare every taken result beat against the oldest prediction
   always @(posedge clock) begin : check_results
      shooter_cmd_type want_cmd;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_cmds.size() == 0) begin
            $error("result beat with no item outstanding");
            mismatches++;
         end else begin
            want_cmd = pending_cmds.pop_front();
            check_field("flywheel_cmd_valid", want_cmd.fly_valid,  rsp_flywheel_cmd_valid);
            check_field("flywheel_rpm_cmd",   want_cmd.fly_rpm,    rsp_flywheel_rpm_cmd);
            check_field("kicker_cmd_valid",   want_cmd.kick_valid, rsp_kicker_cmd_valid);
            check_field("kicker_duty",        want_cmd.kick_duty,  rsp_kicker_duty);
            check_field("hood_cmd_valid",     want_cmd.hood_valid, rsp_hood_cmd_valid);
            check_field("hood_cmd",           want_cmd.hood_cmd,   rsp_hood_cmd);
            check_field("mode",               want_cmd.mode,       rsp_mode);
            n_results++;
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      repeat (9)
         @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_setting_extremes();
      test_random_traffic();
      test_runon_elapse();
      settle_pipeline();
      $display("Sent %0d beats (%0d ticks) over %0d register settings, long run-on included;",
               n_items, n_ticks, n_settings);
      $display("checked %0d result beats against the in-line prediction.", n_results);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/smseq_pkg.sv
hw/rtl/shooter_mode_sequencer_core.sv
tb/sv/tb.sv
